// ===== rtl/core/udpdq_pkg.sv =====
// ----------------------------------------------------------------------------
// udpdq_pkg
// Shared types, codes and constants of the UDP receive port demultiplexer.
// ----------------------------------------------------------------------------
package udpdq_pkg;

   localparam int DEF_QUEUE_DEPTH = 16;
   localparam int DEF_PORT_SLOTS  = 16;
   localparam int SLOT_IDX_W      = 8;    // holds any slot index up to 256 slots

   // operation codes
   localparam logic [1:0] OP_BIND  = 2'd0;
   localparam logic [1:0] OP_FRAME = 2'd1;
   localparam logic [1:0] OP_DEQ   = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   // status codes
   localparam logic [3:0] ST_OK         = 4'd0;
   localparam logic [3:0] ST_TABLE_FULL = 4'd1;
   localparam logic [3:0] ST_NOT_BOUND  = 4'd2;
   localparam logic [3:0] ST_EMPTY      = 4'd3;
   localparam logic [3:0] ST_QUEUED     = 4'd4;
   localparam logic [3:0] ST_ARP_REPLY  = 4'd5;
   localparam logic [3:0] ST_RUNT       = 4'd6;
   localparam logic [3:0] ST_BAD_IP     = 4'd7;
   localparam logic [3:0] ST_BAD_UDP    = 4'd8;
   localparam logic [3:0] ST_NO_PORT    = 4'd9;
   localparam logic [3:0] ST_ARP_REPEAT = 4'd10;

   // frame constants
   localparam logic [15:0] TYPE_ARP    = 16'h0806;
   localparam logic [15:0] TYPE_IPV4   = 16'h0800;
   localparam logic [7:0]  PROTO_UDP   = 8'd17;
   localparam logic [3:0]  IP_VERSION  = 4'd4;
   localparam logic [3:0]  IP_IHL      = 4'd5;
   localparam logic [10:0] MIN_ARP_LEN = 11'd42;
   localparam logic [10:0] MIN_IP_LEN  = 11'd34;
   localparam logic [10:0] MIN_UDP_LEN = 11'd42;
   localparam logic [10:0] HDR_BYTES   = 11'd34;
   localparam logic [15:0] UDP_HDR     = 16'd8;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] port;
      logic [10:0] frame_len;
      logic [15:0] eth_type;
      logic [7:0]  ip_vhl;
      logic [7:0]  ip_proto;
      logic [15:0] udp_len;
      logic [15:0] dest_port;
      logic [31:0] source_ip;
      logic [15:0] source_port;
      logic [7:0]  buffer_id;
      logic [10:0] max_len;
   } req_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [7:0]  out_buffer;
      logic [31:0] out_source_ip;
      logic [15:0] out_source_port;
      logic [10:0] clip_len;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_RESULT = 2'd0,
      CMD_ENQ    = 2'd1,
      CMD_DEQ    = 2'd2
   } cmd_kind_type;

   // front to back command
   typedef struct packed {
      cmd_kind_type           kind;
      logic [3:0]             status;
      logic [SLOT_IDX_W-1:0]  slot;
      logic [7:0]             buffer;
      logic [10:0]            plen;
      logic [31:0]            source_ip;
      logic [15:0]            source_port;
      logic [10:0]            max_len;
   } cmd_type;

endpackage

// ===== rtl/core/udpdq_front.sv =====
// ----------------------------------------------------------------------------
// udpdq_front
// Accepts requests, binds ports, classifies frames, looks up port slots.
// ----------------------------------------------------------------------------
module udpdq_front #(
   parameter int PORT_SLOTS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  udpdq_pkg::req_type req_data,
   output logic              cmd_push,
   output udpdq_pkg::cmd_type cmd_data,
   input  logic              cmd_full
);
   import udpdq_pkg::*;

   localparam int SLOT_W = (PORT_SLOTS > 1) ? $clog2(PORT_SLOTS) : 1;

   logic              port_valid_ff [PORT_SLOTS];
   logic [15:0]       port_ff       [PORT_SLOTS];
   logic              arp_seen_ff, arp_seen_in;
   logic              accept;
   logic [15:0]       key;
   logic              hit, free_found;
   logic [SLOT_IDX_W-1:0] hit_slot, free_slot;
   logic              do_bind_wr;
   logic [10:0]       ip_room;

   assign req_stall = cmd_full;
   assign accept    = req_valid && !cmd_full;
   assign key       = (req_data.op == OP_FRAME) ? req_data.dest_port : req_data.port;
   assign ip_room   = req_data.frame_len - HDR_BYTES;

   // port CAM and free-slot search
   always_comb begin
      hit = 1'b0;
      free_found = 1'b0;
      hit_slot = '0;
      free_slot = '0;
      for (int s = PORT_SLOTS - 1; s >= 0; s--) begin
         if (port_valid_ff[s] && port_ff[s] == key) begin
            hit = 1'b1;
            hit_slot = SLOT_IDX_W'(s);
         end
         if (!port_valid_ff[s]) begin
            free_found = 1'b1;
            free_slot = SLOT_IDX_W'(s);
         end
      end
   end

   always_comb begin
      cmd_data = '0;
      cmd_data.kind = CMD_RESULT;
      cmd_data.buffer = req_data.buffer_id;
      cmd_data.slot = hit_slot;
      cmd_data.max_len = req_data.max_len;
      cmd_data.source_ip = req_data.source_ip;
      cmd_data.source_port = req_data.source_port;
      cmd_data.plen = req_data.udp_len[10:0] - UDP_HDR[10:0];
      arp_seen_in = arp_seen_ff;
      do_bind_wr = 1'b0;
      unique case (req_data.op)
         OP_BIND: begin
            cmd_data.buffer = '0;
            if (hit) begin
               cmd_data.status = ST_OK;
            end else if (free_found) begin
               cmd_data.status = ST_OK;
               do_bind_wr = 1'b1;
            end else begin
               cmd_data.status = ST_TABLE_FULL;
            end
         end
         OP_FRAME: begin
            priority if (req_data.frame_len >= MIN_ARP_LEN && req_data.eth_type == TYPE_ARP) begin
               cmd_data.status = arp_seen_ff ? ST_ARP_REPEAT : ST_ARP_REPLY;
               arp_seen_in = 1'b1;
            end else if (req_data.frame_len < MIN_IP_LEN || req_data.eth_type != TYPE_IPV4
                         || req_data.frame_len < MIN_UDP_LEN) begin
               cmd_data.status = ST_RUNT;
            end else if (req_data.ip_vhl[7:4] != IP_VERSION || req_data.ip_vhl[3:0] != IP_IHL
                         || req_data.ip_proto != PROTO_UDP) begin
               cmd_data.status = ST_BAD_IP;
            end else if (req_data.udp_len < UDP_HDR || req_data.udp_len > {5'd0, ip_room}) begin
               cmd_data.status = ST_BAD_UDP;
            end else if (!hit) begin
               cmd_data.status = ST_NO_PORT;
            end else begin
               cmd_data.kind = CMD_ENQ;
               cmd_data.status = ST_QUEUED;
            end
         end
         OP_DEQ: begin
            cmd_data.buffer = '0;
            if (hit) begin
               cmd_data.kind = CMD_DEQ;
               cmd_data.status = ST_OK;
            end else begin
               cmd_data.status = ST_NOT_BOUND;
            end
         end
         default: begin
            cmd_data.status = ST_OK;
         end
      endcase
   end

   assign cmd_push = accept && (req_data.op != OP_NONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         arp_seen_ff <= 1'b0;
         for (int s = 0; s < PORT_SLOTS; s++) begin
            port_valid_ff[s] <= 1'b0;
         end
      end else if (accept) begin
         if (req_data.op == OP_FRAME) begin
            arp_seen_ff <= arp_seen_in;
         end
         if (do_bind_wr) begin
            port_valid_ff[free_slot[SLOT_W-1:0]] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && do_bind_wr) begin
         port_ff[free_slot[SLOT_W-1:0]] <= req_data.port;
      end
   end

endmodule

// ===== rtl/core/udpdq_cmdq.sv =====
// ----------------------------------------------------------------------------
// udpdq_cmdq
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module udpdq_cmdq (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  udpdq_pkg::cmd_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               out_valid,
   output udpdq_pkg::cmd_type out_data
);
   import udpdq_pkg::*;

   cmd_type     entry_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  cnt_ff;

   assign full      = (cnt_ff == 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

// ===== rtl/core/udpdq_back.sv =====
// ----------------------------------------------------------------------------
// udpdq_back
// Per-slot packet rings: enqueue, dequeue and the result register.
// ----------------------------------------------------------------------------
module udpdq_back #(
   parameter int QUEUE_DEPTH = 16,
   parameter int PORT_SLOTS  = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  udpdq_pkg::cmd_type cmd_data,
   output logic               cmd_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output udpdq_pkg::rsp_type rsp_data
);
   import udpdq_pkg::*;

   localparam int SLOT_W = (PORT_SLOTS > 1) ? $clog2(PORT_SLOTS) : 1;
   localparam int POS_W  = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int MEM_D  = PORT_SLOTS * QUEUE_DEPTH;
   localparam int ADDR_W = $clog2(MEM_D);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(QUEUE_DEPTH - 1);

   typedef struct packed {
      logic [7:0]  buffer;
      logic [10:0] plen;
      logic [31:0] source_ip;
      logic [15:0] source_port;
   } entry_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_READ = 2'b10
   } state_type;

   state_type           state_ff, state_in;
   logic [POS_W-1:0]    head_ff  [PORT_SLOTS];
   logic [POS_W-1:0]    tail_ff  [PORT_SLOTS];
   logic [CNT_W-1:0]    count_ff [PORT_SLOTS];
   entry_type           mem [MEM_D];
   entry_type           rd_ff;
   logic [10:0]         max_len_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_load, rsp_free;
   logic [SLOT_W-1:0]   slot;
   logic [CNT_W-1:0]    cnt;
   logic                wr_en, rd_en;
   logic [ADDR_W-1:0]   wr_addr, rd_addr;
   entry_type           wr_entry;
   logic [POS_W-1:0]    head_nx, tail_nx;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign cmd_pop   = (state_ff == S_IDLE) && cmd_valid && rsp_free;
   assign slot      = cmd_data.slot[SLOT_W-1:0];
   assign cnt       = count_ff[slot];
   assign head_nx   = (head_ff[slot] == LAST_POS) ? '0 : head_ff[slot] + 1'b1;
   assign tail_nx   = (tail_ff[slot] == LAST_POS) ? '0 : tail_ff[slot] + 1'b1;
   assign wr_addr   = ADDR_W'(slot * QUEUE_DEPTH + tail_ff[slot]);
   assign rd_addr   = ADDR_W'(slot * QUEUE_DEPTH + head_ff[slot]);
   assign wr_entry  = '{cmd_data.buffer, cmd_data.plen, cmd_data.source_ip,
                        cmd_data.source_port};
   assign wr_en     = cmd_pop && cmd_data.kind == CMD_ENQ && cnt != FULL_CNT;
   assign rd_en     = cmd_pop && cmd_data.kind == CMD_DEQ && cnt != '0;

   always_comb begin
      state_in = state_ff;
      rsp_load = 1'b0;
      rsp_in   = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_pop) begin
               rsp_in.status = cmd_data.status;
               unique case (cmd_data.kind)
                  CMD_ENQ: begin
                     rsp_load = 1'b1;
                     rsp_in.out_buffer = cmd_data.buffer;
                     if (cnt == FULL_CNT) rsp_in.status = ST_NO_PORT;
                  end
                  CMD_DEQ: begin
                     if (cnt == '0) begin
                        rsp_load = 1'b1;
                        rsp_in.status = ST_EMPTY;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     rsp_load = 1'b1;
                     rsp_in.out_buffer = cmd_data.buffer;
                  end
               endcase
            end
         end
         S_READ: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
               rsp_in.status = ST_OK;
               rsp_in.out_buffer = rd_ff.buffer;
               rsp_in.out_source_ip = rd_ff.source_ip;
               rsp_in.out_source_port = rd_ff.source_port;
               rsp_in.clip_len = (rd_ff.plen < max_len_ff) ? rd_ff.plen : max_len_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ring storage, read register and result register
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_ff      <= mem[rd_addr];
         max_len_ff <= cmd_data.max_len;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < PORT_SLOTS; s++) begin
            head_ff[s]  <= '0;
            tail_ff[s]  <= '0;
            count_ff[s] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (wr_en) begin
            tail_ff[slot]  <= tail_nx;
            count_ff[slot] <= cnt + 1'b1;
         end
         if (rd_en) begin
            head_ff[slot]  <= head_nx;
            count_ff[slot] <= cnt - 1'b1;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cnt <= FULL_CNT)
      else $error("ring count above depth");

   a_enq_result: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> rsp_valid_ff && rsp_ff.status == ST_QUEUED)
      else $error("enqueue without queued result");

   a_read_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ && rsp_free) |=> state_ff == S_IDLE && rsp_valid_ff
                                          && rsp_ff.status == ST_OK)
      else $error("dequeue result not delivered");

   a_read_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ && !$past(state_ff == S_READ)) |-> $past(rd_en))
      else $error("read state without a ring read");

endmodule

// ===== rtl/core/udp_port_demux_queue_core.sv =====
// ----------------------------------------------------------------------------
// udp_port_demux_queue_core
// UDP receive port demultiplexer with per-port packet rings.
// ----------------------------------------------------------------------------
//  channel  | ports                         | moves
//  ---------+-------------------------------+-----------------------------
//  request  | req_valid, req_stall, req_data| bind, frame, dequeue request
//  response | rsp_valid, rsp_stall, rsp_data| one status result per request but OP_NONE
//
// Flow: a request passes the front (port CAM, classify) in its accept
// cycle; the back takes one command per cycle while the response is free,
// and a dequeue that reads the ring memory (registered read) adds S_READ.
// Reset clears the port table, ring pointers and counts, ARP flag and queue;
// ring contents are not cleared. A stalled response holds the back part;
// the two-entry command queue keeps requests flowing until it fills.
// ----------------------------------------------------------------------------
module udp_port_demux_queue_core #(
   parameter int QUEUE_DEPTH = udpdq_pkg::DEF_QUEUE_DEPTH,
   parameter int PORT_SLOTS  = udpdq_pkg::DEF_PORT_SLOTS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  udpdq_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output udpdq_pkg::rsp_type rsp_data
);
   import udpdq_pkg::*;

   logic    push, full, pop, q_valid;
   cmd_type push_data, q_data;

   // front: classification and port binding
   udpdq_front #(.PORT_SLOTS(PORT_SLOTS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_push  (push),
      .cmd_data  (push_data),
      .cmd_full  (full)
   );

   udpdq_cmdq u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .out_valid (q_valid),
      .out_data  (q_data)
   );

   // back: ring memory and response register
   udpdq_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .PORT_SLOTS(PORT_SLOTS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd_data  (q_data),
      .cmd_pop   (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== test/udp_port_demux_queue_core_tb.sv =====
// ----------------------------------------------------------------------------
// udp_port_demux_queue_core_tb
// Self-checking bench for the UDP receive port demultiplexer: binds ports,
// pushes valid and malformed frames, dequeues with random limits, and checks
// every response against a behavioral model of port table and rings.
// ----------------------------------------------------------------------------
module udp_port_demux_queue_core_tb;
   import udpdq_pkg::*;

   localparam int RING_DEPTH = DEF_QUEUE_DEPTH;
   localparam int SLOTS      = DEF_PORT_SLOTS;

   // behavioral demux model plus queue of expected responses
   class demux_scoreboard;
      bit            slot_used[SLOTS];
      logic [15:0]   slot_port[SLOTS];
      int            head[SLOTS], tail[SLOTS], count[SLOTS];
      logic [7:0]    q_buf[SLOTS][RING_DEPTH];
      logic [10:0]   q_plen[SLOTS][RING_DEPTH];
      logic [31:0]   q_ip[SLOTS][RING_DEPTH];
      logic [15:0]   q_sport[SLOTS][RING_DEPTH];
      bit            arp_done;
      rsp_type       pending_rsp[$];
      int            errors;
      int            checked;

      function int find_slot(logic [15:0] p);
         for (int s = 0; s < SLOTS; s++)
            if (slot_used[s] && slot_port[s] == p) return s;
         return -1;
      endfunction

      // note an accepted request and queue its expected response
      function void note_request(req_type r);
         rsp_type e;
         int s;
         e = '0;
         if (r.op == OP_NONE) return;
         if (r.op == OP_BIND) begin
            e.status = ST_OK;
            if (find_slot(r.port) < 0) begin
               e.status = ST_TABLE_FULL;
               for (int k = 0; k < SLOTS; k++)
                  if (!slot_used[k]) begin
                     slot_used[k] = 1; slot_port[k] = r.port;
                     e.status = ST_OK;
                     break;
                  end
            end
         end else if (r.op == OP_FRAME) begin
            e.out_buffer = r.buffer_id;
            if (r.frame_len >= MIN_ARP_LEN && r.eth_type == TYPE_ARP) begin
               e.status = arp_done ? ST_ARP_REPEAT : ST_ARP_REPLY;
               arp_done = 1;
            end else if (r.eth_type != TYPE_IPV4 || r.frame_len < MIN_UDP_LEN)
               e.status = ST_RUNT;
            else if (r.ip_vhl[7:4] != IP_VERSION || r.ip_vhl[3:0] != IP_IHL ||
                     r.ip_proto != PROTO_UDP)
               e.status = ST_BAD_IP;
            else if (r.udp_len < UDP_HDR ||
                     r.udp_len > {5'd0, r.frame_len - HDR_BYTES})
               e.status = ST_BAD_UDP;
            else begin
               s = find_slot(r.dest_port);
               if (s < 0 || count[s] >= RING_DEPTH) e.status = ST_NO_PORT;
               else begin
                  q_buf[s][tail[s]]   = r.buffer_id;
                  q_plen[s][tail[s]]  = 11'(r.udp_len - UDP_HDR);
                  q_ip[s][tail[s]]    = r.source_ip;
                  q_sport[s][tail[s]] = r.source_port;
                  tail[s] = (tail[s] + 1) % RING_DEPTH;
                  count[s]++;
                  e.status = ST_QUEUED;
               end
            end
         end else begin
            s = find_slot(r.port);
            if (s < 0) e.status = ST_NOT_BOUND;
            else if (count[s] == 0) e.status = ST_EMPTY;
            else begin
               e.status          = ST_OK;
               e.out_buffer      = q_buf[s][head[s]];
               e.out_source_ip   = q_ip[s][head[s]];
               e.out_source_port = q_sport[s][head[s]];
               e.clip_len = (q_plen[s][head[s]] < r.max_len) ?
                            q_plen[s][head[s]] : r.max_len;
               head[s] = (head[s] + 1) % RING_DEPTH;
               count[s]--;
            end
         end
         pending_rsp.push_back(e);
      endfunction

      function void check_response(rsp_type a);
         rsp_type e;
         checked++;
         if (pending_rsp.size() == 0) begin
            $error("response with nothing expected: %h", a);
            errors++;
            return;
         end
         e = pending_rsp.pop_front();
         if (a.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, a.status); errors++;
         end
         if (a.out_buffer !== e.out_buffer) begin
            $error("out_buffer exp %h got %h", e.out_buffer, a.out_buffer); errors++;
         end
         if (a.out_source_ip !== e.out_source_ip) begin
            $error("out_source_ip exp %h got %h", e.out_source_ip, a.out_source_ip);
            errors++;
         end
         if (a.out_source_port !== e.out_source_port) begin
            $error("out_source_port exp %h got %h", e.out_source_port,
                   a.out_source_port);
            errors++;
         end
         if (a.clip_len !== e.clip_len) begin
            $error("clip_len exp %0d got %0d", e.clip_len, a.clip_len); errors++;
         end
      endfunction
   endclass

   logic    clock, reset;
   logic    req_valid, req_stall, rsp_valid, rsp_stall;
   req_type req_data;
   rsp_type rsp_data;

   demux_scoreboard board;
   bit      calm;          // no random idling while set
   int      sent;
   logic [15:0] port_pool[24];  // more ports than slots so the table fills

   udp_port_demux_queue_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // hard limit on run time
   initial begin
      #3000000;
      $display("TEST FAILED");
      $finish;
   end

   // response side: check on rising edge, pick stall at falling edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_response(rsp_data);
   end

   always @(negedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 33);
   end

   // drive one request; random idle cycles in front unless calm
   task automatic send_request(req_type r);
      while (!calm && $urandom_range(99) < 33) @(negedge clock);
      req_valid = 1;
      req_data  = r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(r);
      sent++;
      @(negedge clock);
      req_valid = 0;
   endtask

   function automatic req_type noise_request();
      req_type r;
      r = {$urandom, $urandom, $urandom, $urandom, $urandom};
      return r;
   endfunction

   function automatic req_type bind_request(logic [15:0] p);
      req_type r;
      r = noise_request();
      r.op = OP_BIND; r.port = p;
      return r;
   endfunction

   function automatic req_type deq_request(logic [15:0] p, logic [10:0] lim);
      req_type r;
      r = noise_request();
      r.op = OP_DEQ; r.port = p; r.max_len = lim;
      return r;
   endfunction

   // well-formed UDP frame with random content
   function automatic req_type good_frame(logic [15:0] dp);
      req_type r;
      r = noise_request();
      r.op        = OP_FRAME;
      r.eth_type  = TYPE_IPV4;
      r.ip_vhl    = {IP_VERSION, IP_IHL};
      r.ip_proto  = PROTO_UDP;
      r.frame_len = 11'($urandom_range(2047, 42));
      r.udp_len   = 16'($urandom_range(r.frame_len - 34, 8));
      r.dest_port = dp;
      return r;
   endfunction

   task automatic drain();
      while (board.pending_rsp.size() != 0) @(negedge clock);
   endtask

   initial begin
      req_type r;
      int pick;
      board = new();
      calm = 0; sent = 0;
      req_valid = 0; req_data = '0; rsp_stall = 0;
      reset = 1;
      foreach (port_pool[i]) port_pool[i] = 16'($urandom);
      port_pool[0] = 16'h0000; port_pool[1] = 16'hffff;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: unbound dequeue, binds, empty, ARP twice, each drop reason
      send_request(deq_request(16'h0000, 11'd0));
      send_request(bind_request(16'h0000));
      send_request(bind_request(16'h0000));
      send_request(bind_request(16'hffff));
      send_request(deq_request(16'hffff, 11'h7ff));
      r = good_frame(16'h0000); r.eth_type = TYPE_ARP; r.frame_len = 11'd41;
      send_request(r);
      r.frame_len = 11'd42; send_request(r);
      r.frame_len = 11'h7ff; send_request(r);
      r = good_frame(16'h0000); r.frame_len = 11'd41; send_request(r);
      r = good_frame(16'h0000); r.ip_vhl = 8'h46; send_request(r);
      r = good_frame(16'h0000); r.ip_vhl = 8'h55; send_request(r);
      r = good_frame(16'h0000); r.ip_proto = 8'd6; send_request(r);
      r = good_frame(16'h0000); r.udp_len = 16'd7; send_request(r);
      r = good_frame(16'h0000); r.udp_len = 16'hffff; send_request(r);
      r = good_frame(16'h1234); send_request(r);
      r = good_frame(16'h0000); r.frame_len = 11'd42; r.udp_len = 16'd8;
      send_request(r);
      r = good_frame(16'hffff); r.frame_len = 11'h7ff; r.udp_len = 16'd2013;
      r.buffer_id = 8'hff; r.source_ip = '1; r.source_port = '1;
      send_request(r);
      r.op = OP_NONE; send_request(r);
      send_request(deq_request(16'h0000, 11'h7ff));
      send_request(deq_request(16'hffff, 11'd5));
      send_request(deq_request(16'hffff, 11'd5));

      // every response in before the random part
      drain();

      // random: mostly binds/good frames/dequeues over a small port pool
      for (int n = 0; n < 1850; n++) begin
         calm = (n >= 600 && n < 800);
         if (n == 1200) drain();
         pick = $urandom_range(99);
         if (pick < 8)
            r = bind_request(port_pool[$urandom_range(23)]);
         else if (pick < 50)
            r = good_frame(port_pool[$urandom_range(23)]);
         else if (pick < 85)
            r = deq_request(port_pool[$urandom_range(23)], 11'($urandom));
         else if (pick < 95) begin
            r = good_frame(port_pool[$urandom_range(23)]);
            case ($urandom_range(3))
               0: r.eth_type = ($urandom_range(1)) ? TYPE_ARP : 16'($urandom);
               1: r.ip_vhl = 8'($urandom);
               2: r.udp_len = 16'($urandom);
               default: r.frame_len = 11'($urandom_range(50));
            endcase
         end else
            r = noise_request();
         send_request(r);
      end

      drain();
      repeat (20) @(negedge clock);
      $display("Covered %0d requests: binds to a full table, ARP, header drops,", sent);
      $display("ring overflow and clipped dequeues; %0d responses checked.",
               board.checked);
      if (board.errors == 0 && board.pending_rsp.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule

// ===== files.f =====
rtl/core/udpdq_pkg.sv
rtl/core/udpdq_front.sv
rtl/core/udpdq_cmdq.sv
rtl/core/udpdq_back.sv
rtl/core/udp_port_demux_queue_core.sv
test/udp_port_demux_queue_core_tb.sv
